/* hw/rtl/dqmr_pkg.sv */
// Shared types and constants for the deque with match-remove unit.
package dqmr_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int ITEM_W             = 32;
  localparam int COUNT_W            = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_FIND       = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture action and item
    logic exec;   // run push/pop, build match vector
    logic step;   // advance scan position
    logic take;   // match at scan position
    logic miss;   // no entry matched
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t act;
    logic    empty;
    logic    hit;
    logic    scan_end;
  } stat_t;

endpackage

/* hw/rtl/dqmr_ctrl.sv */
// Controller state machine for the deque with match-remove unit.
module dqmr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dqmr_pkg::stat_t stat,
  output logic          busy,
  output logic          done,
  output dqmr_pkg::cmd_t  cmd
);

  dqmr_pkg::state_t state;
  dqmr_pkg::state_t state_next;
  logic             is_search;

  assign is_search = (stat.act == dqmr_pkg::ACT_REMOVE) || (stat.act == dqmr_pkg::ACT_FIND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqmr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dqmr_pkg::S_IDLE: begin
        if (start) state_next = dqmr_pkg::S_EXEC;
      end
      dqmr_pkg::S_EXEC: begin
        if (is_search && !stat.empty) state_next = dqmr_pkg::S_SCAN;
        else                         state_next = dqmr_pkg::S_REPORT;
      end
      dqmr_pkg::S_SCAN: begin
        if (stat.hit || stat.scan_end) state_next = dqmr_pkg::S_REPORT;
      end
      dqmr_pkg::S_REPORT: begin
        state_next = dqmr_pkg::S_IDLE;
      end
      default: state_next = dqmr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      dqmr_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      dqmr_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        // searching an empty store fails at once
        cmd.miss = is_search && stat.empty;
      end
      dqmr_pkg::S_SCAN: begin
        cmd.take = stat.hit;
        cmd.miss = !stat.hit && stat.scan_end;
        cmd.step = !stat.hit && !stat.scan_end;
      end
      dqmr_pkg::S_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* hw/rtl/dqmr_datapath.sv */
// Datapath for the deque with match-remove unit: shift-cell store, match vector, scan index.
module dqmr_datapath #(
  parameter int DEPTH      = dqmr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dqmr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dqmr_pkg::cmd_t               cmd,
  output dqmr_pkg::stat_t              stat,
  input  logic [2:0]                   action,
  input  logic [dqmr_pkg::ITEM_W-1:0]  item,
  output logic [dqmr_pkg::ITEM_W-1:0]  data_out,
  output logic [1:0]                   status,
  output logic [dqmr_pkg::COUNT_W-1:0] entry_count,
  output logic [dqmr_pkg::ITEM_W-1:0]  first_word,
  output logic [dqmr_pkg::ITEM_W-1:0]  last_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] cells      [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      count_m1;
  dqmr_pkg::action_t     act;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_next;
  dqmr_pkg::status_t     status_r;
  dqmr_pkg::status_t     status_next;
  logic [DEPTH-1:0]      match_vec;
  logic [DEPTH-1:0]      match_next;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      idx_next;
  logic [IDX_W-1:0]      tail_addr;
  logic [DATA_WIDTH-1:0] tail;
  logic                  empty;
  logic                  full;

  assign count_m1  = count - CNT_W'(1);
  assign tail_addr = count_m1[IDX_W-1:0];
  assign tail      = cells[tail_addr];
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));

  assign stat.act      = act;
  assign stat.empty    = empty;
  assign stat.hit      = match_vec[idx];
  assign stat.scan_end = (CNT_W'(idx) == count_m1);

  always_comb begin
    cells_next  = cells;
    count_next  = count;
    data_next   = data_r;
    status_next = status_r;
    match_next  = match_vec;
    idx_next    = idx;

    if (cmd.exec) begin
      data_next   = '0;
      status_next = dqmr_pkg::STAT_OK;
      idx_next    = '0;
      for (int i = 0; i < DEPTH; i++) begin
        match_next[i] = (CNT_W'(i) < count) && (cells[i] == key);
      end
      case (act)
        dqmr_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status_next = dqmr_pkg::STAT_FULL;
          end else begin
            for (int i = 1; i < DEPTH; i++) begin
              cells_next[i] = cells[i-1];
            end
            cells_next[0] = key;
            count_next    = count + CNT_W'(1);
          end
        end
        dqmr_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            status_next = dqmr_pkg::STAT_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (IDX_W'(i) == count[IDX_W-1:0]) cells_next[i] = key;
            end
            count_next = count + CNT_W'(1);
          end
        end
        dqmr_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status_next = dqmr_pkg::STAT_EMPTY;
          end else begin
            data_next = cells[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
              cells_next[i] = cells[i+1];
            end
            count_next = count_m1;
          end
        end
        dqmr_pkg::ACT_POP_BACK: begin
          if (empty) begin
            status_next = dqmr_pkg::STAT_EMPTY;
          end else begin
            data_next  = tail;
            count_next = count_m1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.step) idx_next = idx + IDX_W'(1);

    if (cmd.take) begin
      // found word equals the key
      data_next   = key;
      status_next = dqmr_pkg::STAT_OK;
      if (act == dqmr_pkg::ACT_REMOVE) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IDX_W'(i) >= idx) cells_next[i] = cells[i+1];
        end
        count_next = count_m1;
      end
    end

    if (cmd.miss) begin
      data_next   = '0;
      status_next = dqmr_pkg::STAT_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cells     <= cells_next;
    data_r    <= data_next;
    status_r  <= status_next;
    match_vec <= match_next;
    idx       <= idx_next;
    if (cmd.load) begin
      act <= dqmr_pkg::action_t'(action);
      key <= DATA_WIDTH'(item);
    end
  end

  assign data_out    = dqmr_pkg::ITEM_W'(data_r);
  assign status      = status_r;
  assign entry_count = dqmr_pkg::COUNT_W'(count);
  assign first_word  = empty ? '0 : dqmr_pkg::ITEM_W'(cells[0]);
  assign last_word   = empty ? '0 : dqmr_pkg::ITEM_W'(tail);

endmodule

/* hw/rtl/deque_with_match_remove_unit.sv */
// Top level of the deque with match-remove unit: controller plus datapath.
//
// Raise start with action and item while busy is low; the transaction is taken on that
// edge and busy rises. The result appears on data_out, status, entry_count, first_word and
// last_word for exactly one cycle with done high, and must be captured then. Push, pop and
// unused actions go from the execute state to the report state, where done is high, and
// then free the unit. Remove and find compare all entries at once, then a scan counter
// walks the match vector one entry per cycle until the first match or the last entry
// before the report state; an empty store skips the scan.
module deque_with_match_remove_unit #(
  parameter int DEPTH      = dqmr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dqmr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action,
  input  logic [dqmr_pkg::ITEM_W-1:0]  item,
  output logic                         done,
  output logic [dqmr_pkg::ITEM_W-1:0]  data_out,
  output logic [1:0]                   status,
  output logic [dqmr_pkg::COUNT_W-1:0] entry_count,
  output logic [dqmr_pkg::ITEM_W-1:0]  first_word,
  output logic [dqmr_pkg::ITEM_W-1:0]  last_word
);

  dqmr_pkg::cmd_t  cmd;
  dqmr_pkg::stat_t stat;

  dqmr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dqmr_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .item        (item),
    .data_out    (data_out),
    .status      (status),
    .entry_count (entry_count),
    .first_word  (first_word),
    .last_word   (last_word)
  );

endmodule

/* hw/rtl/dqmr_checker.sv */
// Port-level assertions for the deque with match-remove unit, bound to the top level.
module dqmr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [dqmr_pkg::ITEM_W-1:0]  data_out,
  input logic [1:0]                   status,
  input logic [dqmr_pkg::COUNT_W-1:0] entry_count,
  input logic [dqmr_pkg::ITEM_W-1:0]  first_word,
  input logic [dqmr_pkg::ITEM_W-1:0]  last_word
);

  // an accepted transaction keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after acceptance");

  // one result per transaction, then the unit frees up
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe repeated or unit stuck");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result while idle");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    done && entry_count == '0 |-> first_word == '0 && last_word == '0)
    else $error("end words not zero on empty store");

  a_failed_no_data: assert property (@(posedge clk) disable iff (rst)
    done && status != dqmr_pkg::STAT_OK |-> data_out == '0)
    else $error("data on failed action");

endmodule

bind deque_with_match_remove_unit dqmr_checker u_dqmr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .data_out    (data_out),
  .status      (status),
  .entry_count (entry_count),
  .first_word  (first_word),
  .last_word   (last_word)
);

/* dv/tb_deque_with_match_remove_unit.sv */
// Self-checking testbench for the deque with match-remove unit: directed table plus random traffic.
module tb_deque_with_match_remove_unit;

  localparam int DEPTH      = dqmr_pkg::DEPTH_DEFAULT;
  localparam int RAND_ITEMS = 500;
  localparam int DRAIN      = 40;
  localparam int LIMIT      = 200000;
  localparam int MAX_REPORT = 10;

  // action codes with no defined behavior
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [dqmr_pkg::ITEM_W-1:0]  data;
    dqmr_pkg::status_t            st;
    logic [dqmr_pkg::COUNT_W-1:0] count;
    logic [dqmr_pkg::ITEM_W-1:0]  first;
    logic [dqmr_pkg::ITEM_W-1:0]  last;
  } deque_result_t;

  typedef struct {
    logic [2:0]                  act;
    logic [dqmr_pkg::ITEM_W-1:0] word;
    bit                          known;
    deque_result_t               want;
  } plan_row_t;

  logic                          clk;
  logic                          rst   = 1'b1;
  logic                          start = 1'b0;
  logic [2:0]                    action = '0;
  logic [dqmr_pkg::ITEM_W-1:0]   item   = '0;
  logic                          busy;
  logic                          done;
  logic [dqmr_pkg::ITEM_W-1:0]   data_out;
  logic [1:0]                    status;
  logic [dqmr_pkg::COUNT_W-1:0]  entry_count;
  logic [dqmr_pkg::ITEM_W-1:0]   first_word;
  logic [dqmr_pkg::ITEM_W-1:0]   last_word;

  // shadow copy of the deque contents, front at index 0
  logic [dqmr_pkg::ITEM_W-1:0]   shadow [DEPTH];
  int                            shadow_fill = 0;
  deque_result_t                 pending_results [$];
  int                            errors = 0;
  int                            cycles = 0;
  int                            sender_idle_pct = 13;
  logic [dqmr_pkg::ITEM_W-1:0]   pool [4];
  deque_result_t                 got_res;
  deque_result_t                 want_res;

  deque_with_match_remove_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (dqmr_pkg::DATA_WIDTH_DEFAULT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .item        (item),
    .done        (done),
    .data_out    (data_out),
    .status      (status),
    .entry_count (entry_count),
    .first_word  (first_word),
    .last_word   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic deque_result_t mk(logic [dqmr_pkg::ITEM_W-1:0] d, dqmr_pkg::status_t s,
                                       logic [dqmr_pkg::COUNT_W-1:0] c,
                                       logic [dqmr_pkg::ITEM_W-1:0] f,
                                       logic [dqmr_pkg::ITEM_W-1:0] l);
    deque_result_t r;
    r.data  = d;
    r.st    = s;
    r.count = c;
    r.first = f;
    r.last  = l;
    return r;
  endfunction

  // Apply one action to the shadow deque and return the result it should report.
  task automatic apply_action(input logic [2:0] a, input logic [dqmr_pkg::ITEM_W-1:0] w,
                              output deque_result_t r);
    int pos;
    int i;
    r   = '0;
    r.st = dqmr_pkg::STAT_OK;
    pos = -1;
    case (a)
      dqmr_pkg::ACT_PUSH_FRONT, dqmr_pkg::ACT_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          r.st = dqmr_pkg::STAT_FULL;
        end else if (a == dqmr_pkg::ACT_PUSH_FRONT) begin
          for (i = shadow_fill; i > 0; i--) shadow[i] = shadow[i-1];
          shadow[0] = w;
          shadow_fill++;
        end else begin
          shadow[shadow_fill] = w;
          shadow_fill++;
        end
      end
      dqmr_pkg::ACT_POP_FRONT, dqmr_pkg::ACT_POP_BACK: begin
        if (shadow_fill == 0) r.st = dqmr_pkg::STAT_EMPTY;
        else pos = (a == dqmr_pkg::ACT_POP_FRONT) ? 0 : shadow_fill - 1;
      end
      dqmr_pkg::ACT_REMOVE, dqmr_pkg::ACT_FIND: begin
        // first match counting from the front
        for (i = 0; i < shadow_fill; i++) begin
          if (pos < 0 && shadow[i] == w) pos = i;
        end
        if (pos < 0) r.st = dqmr_pkg::STAT_NOMATCH;
      end
      default: ;
    endcase
    if (pos >= 0) begin
      r.data = shadow[pos];
      if (a != dqmr_pkg::ACT_FIND) begin
        for (i = pos; i < shadow_fill - 1; i++) shadow[i] = shadow[i+1];
        shadow_fill--;
      end
    end
    r.count = dqmr_pkg::COUNT_W'(shadow_fill);
    if (shadow_fill > 0) begin
      r.first = shadow[0];
      r.last  = shadow[shadow_fill-1];
    end
  endtask

  // Drive one transaction, hold it until the unit is no longer busy, then queue its expected result.
  task automatic issue(input logic [2:0] a, input logic [dqmr_pkg::ITEM_W-1:0] w,
                       input bit known, input deque_result_t want);
    deque_result_t predicted;
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    action <= a;
    item   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_action(a, w, predicted);
    pending_results.push_back(known ? want : predicted);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [dqmr_pkg::ITEM_W-1:0] pick_word();
    if ($urandom_range(9) < 3) return pool[$urandom_range(3)];
    return $urandom();
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      got_res = {data_out, status, entry_count, first_word, last_word};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("unexpected result: data=%h status=%0d count=%0d first=%h last=%h",
                   data_out, status, entry_count, first_word, last_word);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          errors++;
          if (errors <= MAX_REPORT)
            $display({"mismatch: exp data=%h status=%0d count=%0d first=%h last=%h",
                      " | got data=%h status=%0d count=%0d first=%h last=%h"},
                     want_res.data, want_res.st, want_res.count, want_res.first, want_res.last,
                     data_out, status, entry_count, first_word, last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    plan_row_t                   plan [$];
    logic [2:0]                  a;
    logic [dqmr_pkg::ITEM_W-1:0] w;
    bit                          fill_up;
    int                          r;
    int                          ph;
    int                          n;
    int                          k;

    pool[0] = '0;
    pool[1] = '1;
    pool[2] = $urandom();
    pool[3] = $urandom();
    fill_up = 1'b1;

    // empty store
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_POP_FRONT, 32'h0, 1'b1,
                               mk('0, dqmr_pkg::STAT_EMPTY, 5'd0, '0, '0)});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_POP_BACK, '1, 1'b1,
                               mk('0, dqmr_pkg::STAT_EMPTY, 5'd0, '0, '0)});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_REMOVE, 32'h0, 1'b1,
                               mk('0, dqmr_pkg::STAT_NOMATCH, 5'd0, '0, '0)});
    plan.push_back(plan_row_t'{ACT_SPARE_6, '1, 1'b1,
                               mk('0, dqmr_pkg::STAT_OK, 5'd0, '0, '0)});
    // extremes of the data word
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_PUSH_BACK, '1, 1'b1,
                               mk('0, dqmr_pkg::STAT_OK, 5'd1, '1, '1)});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_PUSH_FRONT, 32'h0, 1'b1,
                               mk('0, dqmr_pkg::STAT_OK, 5'd2, '0, '1)});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_FIND, '1, 1'b1,
                               mk('1, dqmr_pkg::STAT_OK, 5'd2, '0, '1)});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_FIND, 32'h0, 1'b1,
                               mk('0, dqmr_pkg::STAT_OK, 5'd2, '0, '1)});
    // fill to the top, with repeated words for first-match removal
    for (k = 0; k < DEPTH - 2; k++)
      plan.push_back(plan_row_t'{k[0] ? dqmr_pkg::ACT_PUSH_BACK : dqmr_pkg::ACT_PUSH_FRONT,
                                 (k % 4 == 0) ? 32'hA5A5_A5A5 : (32'h8000_0000 >> k),
                                 1'b0, '0});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_PUSH_FRONT, 32'h1, 1'b0, '0});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_REMOVE, 32'hA5A5_A5A5, 1'b0, '0});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_POP_FRONT, 32'h0, 1'b0, '0});
    plan.push_back(plan_row_t'{dqmr_pkg::ACT_POP_BACK, 32'h0, 1'b0, '0});
    plan.push_back(plan_row_t'{ACT_SPARE_7, 32'h0, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p]) issue(plan[p].act, plan[p].word, plan[p].known, plan[p].want);
    wait_drained();

    for (ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 63 : 0;
      for (n = 0; n < RAND_ITEMS / 3; n++) begin
        // swing occupancy between empty and full
        if (n % 40 == 0) fill_up = $urandom_range(1);
        r = $urandom_range(99);
        if (r < 4) a = r[0] ? ACT_SPARE_7 : ACT_SPARE_6;
        else if (r < (fill_up ? 55 : 30))
          a = $urandom_range(1) ? dqmr_pkg::ACT_PUSH_FRONT : dqmr_pkg::ACT_PUSH_BACK;
        else if (r < 75)
          a = $urandom_range(1) ? dqmr_pkg::ACT_POP_FRONT : dqmr_pkg::ACT_POP_BACK;
        else
          a = $urandom_range(1) ? dqmr_pkg::ACT_REMOVE : dqmr_pkg::ACT_FIND;
        if ((a == dqmr_pkg::ACT_REMOVE || a == dqmr_pkg::ACT_FIND) && shadow_fill > 0 &&
            $urandom_range(3) != 0)
          w = shadow[$urandom_range(shadow_fill - 1)];
        else
          w = pick_word();
        issue(a, w, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
